/* hw/rtl/slru_pkg.sv */
// Shared types, constants and helpers for the set-associative LRU cache model.
package slru_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    // leaves of the min-stamp tree, ways rounded up to a power of two
    localparam int WAY_LEAVES = 1 << WAY_W;

    localparam int TAG_W   = 64;
    localparam int ADDR_W  = 64;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;
    localparam int CMD_W   = 2;

    // configuration register widths and indexes
    localparam int CFG_SET_W  = 3;
    localparam int CFG_BLK_W  = 6;
    localparam int CFG_WAYS_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

    // width of the clamped set-bit count
    localparam int SB_W = ($clog2(MAX_SET_BITS + 1) > CFG_SET_W) ?
                          $clog2(MAX_SET_BITS + 1) : CFG_SET_W;
    localparam int SHSUM_W = 7;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    typedef t_line [MAX_WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    // lookup result handed from the way picker to the controller
    typedef struct packed {
        logic             hit;
        logic             evict;
        logic [WAY_W-1:0] way;
    } t_pick;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt} + {{(CNT_W - 1){1'b0}}, inc};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

/* hw/rtl/slru_set_ram.sv */
// Set memory: one row per set holding every way, registered read.
module slru_set_ram (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rd_en,
    input  logic [slru_pkg::SET_AW-1:0]       i_rd_addr,
    output slru_pkg::t_row                    o_rd_data,
    input  logic                              i_wr_en,
    input  logic [slru_pkg::SET_AW-1:0]       i_wr_addr,
    input  slru_pkg::t_row                    i_wr_data
);

    logic [slru_pkg::ROW_W-1:0] mem [slru_pkg::NUM_SETS];
    logic [slru_pkg::ROW_W-1:0] r_rd_q;
    logic [slru_pkg::NUM_SETS-1:0] r_row_vld;
    logic r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= mem[i_rd_addr];
        end
    end

    // rows never written read back as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? slru_pkg::t_row'(r_rd_q) : '0;

endmodule

/* hw/rtl/slru_way_pick.sv */
// Way selection: tag match, first free way, and LRU victim over one set row.
module slru_way_pick (
    input  slru_pkg::t_row                  i_row,
    input  logic [slru_pkg::TAG_W-1:0]      i_tag,
    input  logic [slru_pkg::WCNT_W-1:0]     i_ways,
    output slru_pkg::t_pick                 o_pick
);

    typedef struct packed {
        logic                          en;
        logic [slru_pkg::STAMP_W-1:0]  stamp;
        logic [slru_pkg::WAY_W-1:0]    idx;
    } t_node;

    logic                         hit;
    logic [slru_pkg::WAY_W-1:0]   hit_way;
    logic                         free;
    logic [slru_pkg::WAY_W-1:0]   free_way;
    t_node                        nodes [1:2*slru_pkg::WAY_LEAVES-1];

    // lowest matching way and lowest invalid way among the ways in use
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        for (int i = slru_pkg::MAX_WAYS - 1; i >= 0; i--) begin
            if (slru_pkg::WCNT_W'(i) < i_ways) begin
                if (i_row[i].valid && (i_row[i].tag == i_tag)) begin
                    hit     = 1'b1;
                    hit_way = slru_pkg::WAY_W'(i);
                end
                if (!i_row[i].valid) begin
                    free     = 1'b1;
                    free_way = slru_pkg::WAY_W'(i);
                end
            end
        end
    end

    // min-stamp tree; the left child has the lower way, so it wins ties
    always_comb begin
        for (int i = 0; i < slru_pkg::WAY_LEAVES; i++) begin
            if (i < slru_pkg::MAX_WAYS) begin
                nodes[slru_pkg::WAY_LEAVES + i].en    = (slru_pkg::WCNT_W'(i) < i_ways);
                nodes[slru_pkg::WAY_LEAVES + i].stamp = i_row[i].stamp;
            end else begin
                nodes[slru_pkg::WAY_LEAVES + i].en    = 1'b0;
                nodes[slru_pkg::WAY_LEAVES + i].stamp = '0;
            end
            nodes[slru_pkg::WAY_LEAVES + i].idx = slru_pkg::WAY_W'(i);
        end
        for (int n = slru_pkg::WAY_LEAVES - 1; n >= 1; n--) begin
            if (!nodes[2*n].en) begin
                nodes[n] = nodes[2*n + 1];
            end else if (nodes[2*n + 1].en &&
                         (nodes[2*n + 1].stamp < nodes[2*n].stamp)) begin
                nodes[n] = nodes[2*n + 1];
            end else begin
                nodes[n] = nodes[2*n];
            end
        end
    end

    always_comb begin
        o_pick.hit = hit;
        if (hit) begin
            o_pick.evict = 1'b0;
            o_pick.way   = hit_way;
        end else if (free) begin
            o_pick.evict = 1'b0;
            o_pick.way   = free_way;
        end else begin
            o_pick.evict = 1'b1;
            o_pick.way   = nodes[1].idx;
        end
    end

endmodule

/* hw/rtl/set_assoc_lru_cache_model.sv */
// Set-associative LRU cache model: one access per input beat, one result beat per access.
// Each access runs from input beat to result beat through a decode step that splits the
// address and reads the set row, a lookup step on the registered row (tag compare,
// free-way search, min-stamp tree), and a write-back step that stores the updated row
// and loads the result register; the next beat is taken only in idle. Rate is set by
// the decode, lookup and write-back steps, each access reading and writing its set row
// in the set memory once. The result register lets the next access run while a result
// waits; an access stalls in write-back only while the previous result is still
// untaken. Sets start empty after reset with no clearing pass: each set row has its own
// valid flop. Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data only
// while idle, a rule on the user that the block itself does not enforce.
module set_assoc_lru_cache_model (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [slru_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [slru_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // access stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,  // [63:0] address
    input  logic [1:0]                        s_axis_tuser,  // [1:0] command
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] was_hit, [1] was_miss, [2] was_evict, [3] second_hit,
    // [35:4] hit_total, [67:36] miss_total, [99:68] evict_total, [103:100] zero
    output logic [103:0]                      m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_LOOK,
        S_WRITE
    } t_state;

    t_state r_state;

    logic [slru_pkg::CFG_SET_W-1:0]   r_set_bits;
    logic [slru_pkg::CFG_BLK_W-1:0]   r_blk_bits;
    logic [slru_pkg::CFG_WAYS_W-1:0]  r_ways_cfg;

    logic [slru_pkg::CMD_W-1:0]       r_cmd;
    logic [slru_pkg::ADDR_W-1:0]      r_addr;
    logic [slru_pkg::SET_AW-1:0]      r_set;
    logic [slru_pkg::TAG_W-1:0]       r_tag;
    logic [slru_pkg::WCNT_W-1:0]      r_ways;
    slru_pkg::t_pick                  r_pick;
    logic [slru_pkg::STAMP_W-1:0]     r_clock;

    logic [slru_pkg::CNT_W-1:0]       r_hit_cnt;
    logic [slru_pkg::CNT_W-1:0]       r_miss_cnt;
    logic [slru_pkg::CNT_W-1:0]       r_evict_cnt;
    logic                             r_m_valid;
    logic                             r_was_hit;
    logic                             r_was_miss;
    logic                             r_was_evict;
    logic                             r_second;

    logic [slru_pkg::SB_W-1:0]        s_eff;
    logic [slru_pkg::SHSUM_W-1:0]     sh_sum;
    logic [slru_pkg::ADDR_W-1:0]      addr_sh;
    logic [slru_pkg::SET_AW-1:0]      idx_mask;
    logic [slru_pkg::SET_AW-1:0]      n_set;
    logic [slru_pkg::TAG_W-1:0]       n_tag;
    logic [slru_pkg::WCNT_W-1:0]      n_ways;

    logic                             rd_en;
    logic                             wr_en;
    logic                             out_free;
    logic                             is_access;
    slru_pkg::t_row                   rd_row;
    slru_pkg::t_row                   n_row;
    slru_pkg::t_pick                  pick;
    logic [1:0]                       hit_inc;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= '0;
            r_blk_bits <= '0;
            r_ways_cfg <= slru_pkg::CFG_WAYS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                slru_pkg::CFG_SET_BITS: r_set_bits <= i_cfg_data[slru_pkg::CFG_SET_W-1:0];
                slru_pkg::CFG_BLK_BITS: r_blk_bits <= i_cfg_data[slru_pkg::CFG_BLK_W-1:0];
                slru_pkg::CFG_WAYS:     r_ways_cfg <= i_cfg_data[slru_pkg::CFG_WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- address split ----------------
    always_comb begin
        if (slru_pkg::SB_W'(r_set_bits) > slru_pkg::SB_W'(slru_pkg::MAX_SET_BITS)) begin
            s_eff = slru_pkg::SB_W'(slru_pkg::MAX_SET_BITS);
        end else begin
            s_eff = slru_pkg::SB_W'(r_set_bits);
        end
        sh_sum  = slru_pkg::SHSUM_W'(r_blk_bits) + slru_pkg::SHSUM_W'(s_eff);
        addr_sh = r_addr >> r_blk_bits;
        for (int i = 0; i < slru_pkg::SET_AW; i++) begin
            idx_mask[i] = (slru_pkg::SB_W'(i) < s_eff);
        end
        n_set = addr_sh[slru_pkg::SET_AW-1:0] & idx_mask;
        if (sh_sum >= slru_pkg::SHSUM_W'(64)) begin
            n_tag = '0;
        end else begin
            n_tag = r_addr >> sh_sum[5:0];
        end
        if (r_ways_cfg == '0) begin
            n_ways = slru_pkg::WCNT_W'(1);
        end else if (slru_pkg::WCNT_W'(r_ways_cfg) >
                     slru_pkg::WCNT_W'(slru_pkg::MAX_WAYS)) begin
            n_ways = slru_pkg::WCNT_W'(slru_pkg::MAX_WAYS);
        end else begin
            n_ways = slru_pkg::WCNT_W'(r_ways_cfg);
        end
    end

    // ---------------- set memory and lookup ----------------
    assign rd_en     = (r_state == S_DECODE);
    assign out_free  = !r_m_valid || m_axis_tready;
    assign is_access = (r_cmd != slru_pkg::CMD_NONE);
    assign wr_en     = (r_state == S_WRITE) && out_free && is_access;

    slru_set_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (n_set),
        .o_rd_data (rd_row),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_set),
        .i_wr_data (n_row)
    );

    slru_way_pick u_pick (
        .i_row  (rd_row),
        .i_tag  (r_tag),
        .i_ways (r_ways),
        .o_pick (pick)
    );

    // read data stays put until the next read, so write-back merges into it
    always_comb begin
        n_row = rd_row;
        n_row[r_pick.way].stamp = r_clock;
        if (!r_pick.hit) begin
            n_row[r_pick.way].valid = 1'b1;
            n_row[r_pick.way].tag   = r_tag;
        end
        hit_inc = {1'b0, r_pick.hit} + {1'b0, (r_cmd == slru_pkg::CMD_MODIFY)};
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clock     <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            r_m_valid   <= 1'b0;
            r_was_hit   <= 1'b0;
            r_was_miss  <= 1'b0;
            r_was_evict <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            // write-back reloads the result register itself
            if (r_m_valid && m_axis_tready && (r_state != S_WRITE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_clock <= r_clock + 1'b1;
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        if (is_access) begin
                            r_was_hit   <= r_pick.hit;
                            r_was_miss  <= !r_pick.hit;
                            r_was_evict <= r_pick.evict;
                            r_second    <= (r_cmd == slru_pkg::CMD_MODIFY);
                            r_hit_cnt   <= slru_pkg::sat_add(r_hit_cnt, hit_inc);
                            r_miss_cnt  <= slru_pkg::sat_add(r_miss_cnt,
                                                             {1'b0, !r_pick.hit});
                            r_evict_cnt <= slru_pkg::sat_add(r_evict_cnt,
                                                             {1'b0, r_pick.evict});
                        end else begin
                            r_was_hit   <= 1'b0;
                            r_was_miss  <= 1'b0;
                            r_was_evict <= 1'b0;
                            r_second    <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd  <= s_axis_tuser;
            r_addr <= s_axis_tdata;
        end
        if (r_state == S_DECODE) begin
            r_set  <= n_set;
            r_tag  <= n_tag;
            r_ways <= n_ways;
        end
        if (r_state == S_LOOK) begin
            r_pick <= pick;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0000, r_evict_cnt, r_miss_cnt, r_hit_cnt,
                            r_second, r_was_evict, r_was_miss, r_was_hit};

    // ---------------- assertions ----------------
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_DECODE))
        else $error("accepted beat did not start decode");

    a_read_then_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> (r_state == S_LOOK))
        else $error("set read not followed by lookup");

    a_write_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_state == S_IDLE) && m_axis_tvalid)
        else $error("write-back did not produce a result beat");

    a_hit_miss_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_was_hit && r_was_miss) && (!r_was_evict || r_was_miss))
        else $error("inconsistent hit/miss/evict flags");

    a_second_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_second) |-> (r_hit_cnt != '0))
        else $error("modify store hit not counted");

endmodule
